// File: design/ihex_pkg.sv
// Shared types, constants and digit decoding for the Intel HEX record parser.
package ihex_pkg;

    // ASCII codes the parser reacts to
    localparam logic [7:0] CHAR_COLON   = 8'd58;
    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_ZERO    = 8'd48;
    localparam logic [7:0] CHAR_UPPER_A = 8'd65;
    localparam logic [7:0] CHAR_UPPER_F = 8'd70;
    localparam logic [7:0] CHAR_LOWER_A = 8'd97;
    localparam logic [7:0] CHAR_LOWER_F = 8'd102;
    localparam logic [7:0] NIBBLE_ALPHA = 8'd10;

    // Record types
    localparam logic [7:0] REC_DATA = 8'd0;
    localparam logic [7:0] REC_EOF  = 8'd1;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_WRITE     = 2'd0,
        KIND_EOF       = 2'd1,
        KIND_NO_COLON  = 2'd2,
        KIND_BAD_TYPE  = 2'd3
    } kind_t;

    // Parser phases, one-hot
    typedef enum logic [6:0] {
        PH_COLON = 7'b0000001,
        PH_COUNT = 7'b0000010,
        PH_ADDR  = 7'b0000100,
        PH_TYPE  = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_SKIP  = 7'b0100000,
        PH_HALT  = 7'b1000000
    } phase_t;

    // Architectural parser state
    typedef struct packed {
        phase_t      phase;
        logic [1:0]  digit_count;
        logic [15:0] field_value;
        logic [7:0]  bytes_left;
        logic [15:0] load_address;
        logic [3:0]  high_nibble;
    } ihex_state_t;

    // One result beat
    typedef struct packed {
        logic        valid;
        kind_t       kind;
        logic [15:0] write_address;
        logic [7:0]  write_byte;
    } ihex_result_t;

    // Hex digit value; anything that is not A-F/a-f is taken as (code - '0') mod 16
    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] v;
        begin
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)
                v = c - CHAR_UPPER_A + NIBBLE_ALPHA;
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
                v = c - CHAR_LOWER_A + NIBBLE_ALPHA;
            else
                v = c - CHAR_ZERO;
            return v[3:0];
        end
    endfunction

endpackage

// File: design/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser: input register, decoder and result register.
//
// Takes one ASCII character of an Intel HEX file per beat and one per clock cycle
// when the output side keeps up; a character's result (a memory write or a status)
// is registered: the character sits in the input register until the result slot
// is free, and the decoder's output then lands in the result register. While a
// result waits on the output side, the character behind it is held and input stalls.
// Throughput is set by the single parser state update per cycle. Kind 0 is a byte
// write; kinds 1 (end of file), 2 (missing colon) and 3 (unsupported record type)
// are final: after one of them all further characters are accepted and ignored
// until reset. Checksums are not verified and digits are not validated.
module intel_hex_record_parser
    import ihex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ascii_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] write_address,
    output logic [7:0]  write_byte
);

    logic         char_valid_reg;
    logic [7:0]   char_reg;
    ihex_state_t  state_reg;
    ihex_state_t  state_next;
    ihex_result_t result;
    logic         out_valid_reg;
    kind_t        kind_reg;
    logic [15:0]  addr_reg;
    logic [7:0]   byte_reg;
    logic         out_free;
    logic         advance;

    // Handshake: decode when the result slot is free or being emptied
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = char_valid_reg && out_free;
    assign in_ready = !char_valid_reg || out_free;

    ihex_decoder u_decoder (
        .state      (state_reg),
        .ascii_char (char_reg),
        .state_next (state_next),
        .result     (result)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            char_valid_reg <= 1'b0;
        else if (in_valid && in_ready)
            char_valid_reg <= 1'b1;
        else if (advance)
            char_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            char_reg <= ascii_char;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_COLON;
            state_reg.digit_count  <= '0;
            state_reg.field_value  <= '0;
            state_reg.bytes_left   <= '0;
            state_reg.load_address <= '0;
            state_reg.high_nibble  <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && result.valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            kind_reg <= result.kind;
            addr_reg <= result.write_address;
            byte_reg <= result.write_byte;
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign write_address = addr_reg;
    assign write_byte    = byte_reg;

    // A status result is always final
    a_status_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_WRITE) |-> state_reg.phase == PH_HALT)
        else $error("status result without halted parser");

    // Once halted with nothing pending, no result ever appears
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase == PH_HALT && !out_valid_reg) |=> !out_valid_reg)
        else $error("result produced after halt");

    // Status results carry zero address and data
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_WRITE) |-> (addr_reg == '0 && byte_reg == '0))
        else $error("status result with nonzero payload");

    // Consecutive writes within a record step the address by one
    a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && result.valid && result.kind == KIND_WRITE)
            |=> state_reg.load_address == addr_reg + 16'd1)
        else $error("load address did not advance after write");

endmodule

// File: design/ihex_decoder.sv
// Per-character next-state and result logic of the Intel HEX parser.
module ihex_decoder
    import ihex_pkg::*;
(
    input  ihex_state_t  state,
    input  logic [7:0]   ascii_char,
    output ihex_state_t  state_next,
    output ihex_result_t result
);

    logic [3:0]  nib;
    logic [15:0] field_shift;
    logic        field_done;
    logic [7:0]  byte_val;

    assign nib         = nibble_of(ascii_char);
    assign field_shift = {state.field_value[11:0], nib};
    assign field_done  = (state.phase == PH_ADDR) ? (state.digit_count == 2'd3)
                                                  : (state.digit_count == 2'd1);
    assign byte_val    = {state.high_nibble, nib};

    // Step the parser by one character
    always_comb
    begin
        state_next           = state;
        result.valid         = 1'b0;
        result.kind          = KIND_WRITE;
        result.write_address = '0;
        result.write_byte    = '0;

        if (state.phase == PH_HALT)
        begin
            state_next = state;
        end
        else if (state.phase == PH_COLON)
        begin
            if (ascii_char == CHAR_COLON)
            begin
                state_next.phase       = PH_COUNT;
                state_next.digit_count = '0;
                state_next.field_value = '0;
            end
            else
            begin
                state_next.phase = PH_HALT;
                result.valid     = 1'b1;
                result.kind      = KIND_NO_COLON;
            end
        end
        else if (ascii_char == CHAR_LF)
        begin
            // line ends: drop any partial record
            state_next.phase       = PH_COLON;
            state_next.digit_count = '0;
            state_next.field_value = '0;
        end
        else
        begin
            unique case (state.phase)
                PH_COUNT, PH_ADDR, PH_TYPE:
                begin
                    state_next.field_value = field_shift;
                    if (field_done)
                    begin
                        state_next.digit_count = '0;
                        state_next.field_value = '0;
                        if (state.phase == PH_COUNT)
                        begin
                            state_next.bytes_left = field_shift[7:0];
                            state_next.phase      = PH_ADDR;
                        end
                        else if (state.phase == PH_ADDR)
                        begin
                            state_next.load_address = field_shift;
                            state_next.phase        = PH_TYPE;
                        end
                        else if (field_shift[7:0] == REC_DATA)
                        begin
                            state_next.phase = (state.bytes_left == '0) ? PH_SKIP : PH_DATA;
                        end
                        else
                        begin
                            state_next.phase = PH_HALT;
                            result.valid     = 1'b1;
                            result.kind      = (field_shift[7:0] == REC_EOF) ? KIND_EOF
                                                                            : KIND_BAD_TYPE;
                        end
                    end
                    else
                    begin
                        state_next.digit_count = state.digit_count + 2'd1;
                    end
                end
                PH_DATA:
                begin
                    if (state.digit_count == 2'd0)
                    begin
                        state_next.high_nibble = nib;
                        state_next.digit_count = 2'd1;
                    end
                    else
                    begin
                        state_next.digit_count  = '0;
                        state_next.load_address = state.load_address + 16'd1;
                        state_next.bytes_left   = state.bytes_left - 8'd1;
                        if (state.bytes_left == 8'd1)
                            state_next.phase = PH_SKIP;
                        result.valid         = 1'b1;
                        result.kind          = KIND_WRITE;
                        result.write_address = state.load_address;
                        result.write_byte    = byte_val;
                    end
                end
                default:
                begin
                    // skipping checksum and trailing text
                    state_next = state;
                end
            endcase
        end
    end

endmodule
